### rtl/core/mfb_pkg.sv
// Package for the multichannel FIR filter bank core.
// Item payload types, command codes and field widths; no dependencies.
`timescale 1ns / 1ps

package mfb_pkg;

   // fixed field widths of the item payloads
   localparam int STATION_W = 2;
   localparam int BANK_W    = 8;
   localparam int TAP_W     = 4;
   localparam int FIELD_W   = 16;
   localparam int OUT_W     = 36;

   // command codes
   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_COEF   = 1'b1;

   typedef struct packed {
      logic                        command;
      logic [STATION_W-1:0]        in_station;
      logic [BANK_W-1:0]           in_bank;
      logic [TAP_W-1:0]            tap_index;
      logic signed [FIELD_W-1:0]   sample_re;
      logic signed [FIELD_W-1:0]   sample_im;
      logic signed [FIELD_W-1:0]   coefficient;
   } req_type;

   typedef struct packed {
      logic [STATION_W-1:0]        out_station;
      logic [BANK_W-1:0]           out_bank;
      logic signed [OUT_W-1:0]     filtered_re;
      logic signed [OUT_W-1:0]     filtered_im;
   } rsp_type;

   // control that travels with each tap through the multiply-accumulate unit
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

### rtl/core/mfb_stream_if.sv
// Valid/ready item channel for the multichannel FIR filter bank core.
// Payload type is a parameter; used with the types of mfb_pkg.
`timescale 1ns / 1ps

interface mfb_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/mfb_mac.sv
// Shared complex-by-real multiply-accumulate unit of the FIR filter bank.
// Two-stage pipe: registered products, then accumulate; uses mfb_pkg.
`timescale 1ns / 1ps

module mfb_mac #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 16,
   parameter int ACC_WIDTH    = 36
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mfb_pkg::mac_ctl_type          ctl,
   input  logic signed [COEF_WIDTH-1:0]  coef,
   input  logic signed [SAMPLE_WIDTH-1:0] samp_re,
   input  logic signed [SAMPLE_WIDTH-1:0] samp_im,
   output logic signed [ACC_WIDTH-1:0]   acc_re,
   output logic signed [ACC_WIDTH-1:0]   acc_im,
   output logic                          done
);

   localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;

   mfb_pkg::mac_ctl_type         ctl_ff;
   logic signed [PROD_W-1:0]     prod_re_ff, prod_im_ff;
   logic signed [ACC_WIDTH-1:0]  acc_re_ff, acc_im_ff;
   logic signed [ACC_WIDTH-1:0]  acc_re_in, acc_im_in;
   logic                         done_ff;

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
      prod_re_ff <= coef * samp_re;
      prod_im_ff <= coef * samp_im;
   end

   // accumulate, restarting on the first tap of an item
   always_comb begin
      if (ctl_ff.first) begin
         acc_re_in = ACC_WIDTH'(prod_re_ff);
         acc_im_in = ACC_WIDTH'(prod_im_ff);
      end else begin
         acc_re_in = acc_re_ff + ACC_WIDTH'(prod_re_ff);
         acc_im_in = acc_im_ff + ACC_WIDTH'(prod_im_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= ctl_ff.valid && ctl_ff.last;
      end
      if (ctl_ff.valid) begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
   end

   assign acc_re = acc_re_ff;
   assign acc_im = acc_im_ff;
   assign done   = done_ff;

endmodule

### rtl/core/multichannel_fir_filter_bank_core.sv
// Top level of the multichannel FIR filter bank core (polyphase FIR front end).
// Uses mfb_pkg, mfb_stream_if and the shared multiply-accumulate unit mfb_mac.
`timescale 1ns / 1ps

// After reset the core runs a clearing pass over all STATIONS*BANKS*TAPS
// delay-line entries (16384 at the default sizes), one entry a cycle; the
// write pointers are cleared in the same pass and no item is taken until
// it ends. A coefficient write is taken straight from the item and the core
// stays ready. From accept until the core is ready again, a sample item goes through
// the pointer read and sample write, then one tap per cycle through the single
// complex-by-real multiply-accumulate unit, whose two pipeline stages drain
// before the result is loaded into the output register. A result waiting in
// the output register does not hold up the next item until that item's own
// result is due. Sample items with a station or bank out of range, and
// coefficient writes with a bank or tap out of range, are dropped silently.
// Coefficients must be written before a sample of their bank is filtered.

module multichannel_fir_filter_bank_core #(
   parameter int STATIONS     = 4,
   parameter int BANKS        = 256,
   parameter int TAPS         = 16,
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 16
) (
   input  logic         clock,
   input  logic         reset,
   mfb_stream_if.sink   req_chan,
   mfb_stream_if.source rsp_chan
);

   localparam int PAIRS    = STATIONS * BANKS;
   localparam int DL_DEPTH = PAIRS * TAPS;
   localparam int CF_DEPTH = BANKS * TAPS;
   localparam int TAP_AW   = $clog2(TAPS);
   localparam int PAIR_AW  = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int DL_AW    = $clog2(DL_DEPTH);
   localparam int CF_AW    = (CF_DEPTH > 1) ? $clog2(CF_DEPTH) : 1;
   localparam int BANK_AW  = (BANKS > 1) ? $clog2(BANKS) : 1;
   localparam int ACC_W    = SAMPLE_WIDTH + COEF_WIDTH + TAP_AW;
   localparam int SEXT_W   = (SAMPLE_WIDTH > mfb_pkg::FIELD_W) ? SAMPLE_WIDTH
                                                               : mfb_pkg::FIELD_W;
   localparam int CEXT_W   = (COEF_WIDTH > mfb_pkg::FIELD_W) ? COEF_WIDTH
                                                             : mfb_pkg::FIELD_W;

   // sequencer states
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_PTR   = 3'd2;
   localparam logic [2:0] ST_WRITE = 3'd3;
   localparam logic [2:0] ST_MAC   = 3'd4;
   localparam logic [2:0] ST_WAIT  = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]                     state_ff, state_in;

   // memories
   logic [2*SAMPLE_WIDTH-1:0]      delay_mem [DL_DEPTH];
   logic [COEF_WIDTH-1:0]          coef_mem  [CF_DEPTH];
   logic [TAP_AW-1:0]              ptr_mem   [PAIRS];

   // item registers
   logic [mfb_pkg::STATION_W-1:0]  station_ff;
   logic [mfb_pkg::BANK_W-1:0]     bank_ff;
   logic [SAMPLE_WIDTH-1:0]        samp_re_ff, samp_im_ff;
   logic [PAIR_AW-1:0]             pair_ff;
   logic [DL_AW-1:0]               base_ff;
   logic [CF_AW-1:0]               cbase_ff;
   logic [TAP_AW-1:0]              ptr_rd_ff;
   logic [TAP_AW-1:0]              pos_ff, k_ff;
   logic [DL_AW-1:0]               clr_ff;

   // memory read data and the control that goes with it
   logic [2*SAMPLE_WIDTH-1:0]      dl_rd_ff;
   logic [COEF_WIDTH-1:0]          cf_rd_ff;
   mfb_pkg::mac_ctl_type           rd_ctl_ff, issue_ctl;

   // output register
   logic                           rsp_valid_ff;
   mfb_pkg::rsp_type               rsp_data_ff;

   logic                           req_fire, samp_ok, coef_ok;
   logic [SEXT_W-1:0]              ext_re, ext_im;
   logic [CEXT_W-1:0]              ext_coef;
   logic [TAP_AW-1:0]              ptr_cur, ptr_next;
   logic                           dl_we;
   logic [DL_AW-1:0]               dl_waddr;
   logic [2*SAMPLE_WIDTH-1:0]      dl_wdata;
   logic                           ptr_we;
   logic [PAIR_AW-1:0]             ptr_waddr;
   logic [TAP_AW-1:0]              ptr_wdata;
   logic                           clr_last, tap_last, rsp_free;
   logic signed [ACC_W-1:0]        acc_re, acc_im;
   logic                           mac_done;

   // input handshake and range checks
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign samp_ok  = (32'(req_chan.payload.in_station) < STATIONS)
                  && (32'(req_chan.payload.in_bank) < BANKS);
   assign coef_ok  = (32'(req_chan.payload.in_bank) < BANKS)
                  && (32'(req_chan.payload.tap_index) < TAPS);
   assign ext_re   = SEXT_W'($unsigned(req_chan.payload.sample_re));
   assign ext_im   = SEXT_W'($unsigned(req_chan.payload.sample_im));
   assign ext_coef = CEXT_W'($unsigned(req_chan.payload.coefficient));

   assign clr_last = (clr_ff == DL_AW'(DL_DEPTH - 1));
   assign tap_last = (k_ff == TAP_AW'(TAPS - 1));
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // pointer of this item, and its successor with wrap
   assign ptr_cur  = (32'(ptr_rd_ff) >= TAPS) ? '0 : ptr_rd_ff;
   assign ptr_next = (ptr_cur == TAP_AW'(TAPS - 1)) ? '0 : ptr_cur + 1'b1;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_fire && req_chan.payload.command == mfb_pkg::CMD_FILTER && samp_ok) begin
               state_in = ST_PTR;
            end
         end
         ST_PTR:   state_in = ST_WRITE;
         ST_WRITE: state_in = ST_MAC;
         ST_MAC:   if (tap_last) state_in = ST_WAIT;
         ST_WAIT:  if (mac_done) state_in = ST_OUT;
         ST_OUT:   if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   // item capture and address bases
   always_ff @(posedge clock) begin
      if (req_fire) begin
         station_ff <= req_chan.payload.in_station;
         bank_ff    <= req_chan.payload.in_bank;
         samp_re_ff <= ext_re[SAMPLE_WIDTH-1:0];
         samp_im_ff <= ext_im[SAMPLE_WIDTH-1:0];
         pair_ff    <= PAIR_AW'(32'(req_chan.payload.in_station) * BANKS
                              + 32'(req_chan.payload.in_bank));
      end
      if (state_ff == ST_PTR) begin
         base_ff  <= DL_AW'(32'(pair_ff) * TAPS);
         cbase_ff <= CF_AW'(32'(bank_ff[BANK_AW-1:0]) * TAPS);
      end
   end

   // tap walk: coefficient index up, delay position down from the newest
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         pos_ff <= ptr_cur;
         k_ff   <= '0;
      end else if (state_ff == ST_MAC) begin
         pos_ff <= (pos_ff == '0) ? TAP_AW'(TAPS - 1) : pos_ff - 1'b1;
         k_ff   <= k_ff + 1'b1;
      end
   end

   // write port selection: clearing pass or new sample
   always_comb begin
      dl_we     = 1'b0;
      dl_waddr  = DL_AW'(base_ff + DL_AW'(ptr_cur));
      dl_wdata  = {samp_im_ff, samp_re_ff};
      ptr_we    = 1'b0;
      ptr_waddr = pair_ff;
      ptr_wdata = ptr_next;
      if (state_ff == ST_CLEAR) begin
         dl_we     = 1'b1;
         dl_waddr  = clr_ff;
         dl_wdata  = '0;
         ptr_we    = (32'(clr_ff) < PAIRS);
         ptr_waddr = clr_ff[PAIR_AW-1:0];
         ptr_wdata = '0;
      end else if (state_ff == ST_WRITE) begin
         dl_we  = 1'b1;
         ptr_we = 1'b1;
      end
   end

   // delay-line memory
   always_ff @(posedge clock) begin
      if (dl_we) begin
         delay_mem[dl_waddr] <= dl_wdata;
      end
   end

   always_ff @(posedge clock) begin
      dl_rd_ff <= delay_mem[DL_AW'(base_ff + DL_AW'(pos_ff))];
   end

   // coefficient memory, written straight from the item
   always_ff @(posedge clock) begin
      if (req_fire && req_chan.payload.command == mfb_pkg::CMD_COEF && coef_ok) begin
         coef_mem[CF_AW'(32'(req_chan.payload.in_bank) * TAPS
                         + 32'(req_chan.payload.tap_index))] <= ext_coef[COEF_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      cf_rd_ff <= coef_mem[CF_AW'(cbase_ff + CF_AW'(k_ff))];
   end

   // write pointer memory
   always_ff @(posedge clock) begin
      if (ptr_we) begin
         ptr_mem[ptr_waddr] <= ptr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      ptr_rd_ff <= ptr_mem[pair_ff];
   end

   // control is registered alongside the memory reads, so the two stay aligned
   always_comb begin
      issue_ctl.valid = (state_ff == ST_MAC);
      issue_ctl.first = (k_ff == '0);
      issue_ctl.last  = tap_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ctl_ff <= '0;
      end else begin
         rd_ctl_ff <= issue_ctl;
      end
   end

   mfb_mac #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH),
      .ACC_WIDTH    (ACC_W)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rd_ctl_ff),
      .coef    (cf_rd_ff),
      .samp_re (dl_rd_ff[SAMPLE_WIDTH-1:0]),
      .samp_im (dl_rd_ff[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .acc_re  (acc_re),
      .acc_im  (acc_im),
      .done    (mac_done)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_data_ff.out_station <= station_ff;
         rsp_data_ff.out_bank    <= bank_ff;
         rsp_data_ff.filtered_re <= mfb_pkg::OUT_W'(acc_re);
         rsp_data_ff.filtered_im <= mfb_pkg::OUT_W'(acc_im);
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

### bench/tb_multichannel_fir_filter_bank_core.sv
// Testbench for multichannel_fir_filter_bank_core: random valid/ready traffic, scoreboard
// against a behavioral filter of per-pair delay lines and per-bank coefficients.
// Depends on mfb_pkg, mfb_stream_if and the core itself.
`timescale 1ns / 1ps

module tb_multichannel_fir_filter_bank_core;

   localparam int NUM_STATIONS = 4;
   localparam int NUM_BANKS    = 256;
   localparam int NUM_TAPS     = 16;
   localparam int ITEM_TARGET  = 1200;
   localparam int DRAIN_CYCLES = 2 * (NUM_TAPS + 6);

   // receiver stall modes
   localparam int STALL_NONE   = 0;
   localparam int STALL_RANDOM = 1;
   localparam int STALL_SPARSE = 2;

   typedef struct {
      mfb_pkg::req_type item;
      bit               wait_idle;
   } queued_req_type;

   logic clock;
   logic reset;

   mfb_stream_if #(.payload_type(mfb_pkg::req_type)) req_chan ();
   mfb_stream_if #(.payload_type(mfb_pkg::rsp_type)) rsp_chan ();

   multichannel_fir_filter_bank_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // behavioral copy of the core state
   logic signed [mfb_pkg::FIELD_W-1:0] line_re   [0:NUM_STATIONS*NUM_BANKS*NUM_TAPS-1];
   logic signed [mfb_pkg::FIELD_W-1:0] line_im   [0:NUM_STATIONS*NUM_BANKS*NUM_TAPS-1];
   logic        [mfb_pkg::TAP_W-1:0]   line_head [0:NUM_STATIONS*NUM_BANKS-1];
   logic signed [mfb_pkg::FIELD_W-1:0] bank_coef [0:NUM_BANKS*NUM_TAPS-1];

   queued_req_type   item_backlog[$];
   mfb_pkg::rsp_type predicted_results[$];
   int               mismatch_count = 0;
   bit               req_taken = 1'b0;

   // sender and receiver pacing
   int burst_left = 1;
   int gap_left = 0;
   int stall_mode = STALL_NONE;
   int mode_left = 0;
   int stall_phase = 0;

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // store the sample at the pair's head, then sum coefficient k times the sample k items old
   function automatic mfb_pkg::rsp_type filter_sample(mfb_pkg::req_type it);
      int                        pair;
      int                        base;
      int                        coef_base;
      logic [mfb_pkg::TAP_W-1:0] slot;
      logic [mfb_pkg::TAP_W-1:0] pos;
      longint                    acc_re;
      longint                    acc_im;
      mfb_pkg::rsp_type          r;
      pair      = int'(it.in_station) * NUM_BANKS + int'(it.in_bank);
      base      = pair * NUM_TAPS;
      coef_base = int'(it.in_bank) * NUM_TAPS;
      slot      = line_head[pair];
      line_re[base + slot] = it.sample_re;
      line_im[base + slot] = it.sample_im;
      acc_re = 0;
      acc_im = 0;
      for (int k = 0; k < NUM_TAPS; k++) begin
         pos = slot - mfb_pkg::TAP_W'(k);
         acc_re += longint'(bank_coef[coef_base + k]) * longint'(line_re[base + pos]);
         acc_im += longint'(bank_coef[coef_base + k]) * longint'(line_im[base + pos]);
      end
      line_head[pair] = slot + 1'b1;
      r.out_station = it.in_station;
      r.out_bank    = it.in_bank;
      r.filtered_re = acc_re[mfb_pkg::OUT_W-1:0];
      r.filtered_im = acc_im[mfb_pkg::OUT_W-1:0];
      return r;
   endfunction

   function automatic mfb_pkg::req_type rand_req();
      logic [63:0] bits;
      bits = {$urandom(), $urandom()};
      return bits[$bits(mfb_pkg::req_type)-1:0];
   endfunction

   // mostly random, now and then a corner value
   function automatic logic signed [mfb_pkg::FIELD_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return mfb_pkg::FIELD_W'($urandom());
      endcase
   endfunction

   task automatic report_field(string field_name, logic signed [63:0] want,
                               logic signed [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t ns: %s expected %0d, got %0d", $time, field_name, want, got);
      end
   endtask

   // sender: items change on the falling edge, in bursts with gaps
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (item_backlog.size() == 0 ||
                      (item_backlog[0].wait_idle && predicted_results.size() != 0)) begin
            req_chan.valid <= 1'b0;
         end else begin
            req_chan.payload <= item_backlog[0].item;
            req_chan.valid   <= 1'b1;
            item_backlog.pop_front();
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // receiver: ready follows a randomly chosen stall mode: always ready, random or sparse
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(STALL_NONE, STALL_SPARSE);
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      stall_phase++;
      case (stall_mode)
         STALL_NONE:   rsp_chan.ready <= 1'b1;
         STALL_RANDOM: rsp_chan.ready <= 1'($urandom_range(0, 1));
         default:      rsp_chan.ready <= (stall_phase % 4 == 0);
      endcase
   end

   // monitor: predict on each accepted item, check each accepted result
   always @(posedge clock) begin
      req_taken = !reset && req_chan.valid && req_chan.ready;
      if (req_taken) begin
         if (req_chan.payload.command == mfb_pkg::CMD_COEF) begin
            bank_coef[int'(req_chan.payload.in_bank) * NUM_TAPS +
                      int'(req_chan.payload.tap_index)] = req_chan.payload.coefficient;
         end else begin
            predicted_results.push_back(filter_sample(req_chan.payload));
         end
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (predicted_results.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: unexpected item, station %0d bank %0d", $time,
                     rsp_chan.payload.out_station, rsp_chan.payload.out_bank);
         end else begin
            mfb_pkg::rsp_type want;
            want = predicted_results.pop_front();
            report_field("out_station", want.out_station, rsp_chan.payload.out_station);
            report_field("out_bank", want.out_bank, rsp_chan.payload.out_bank);
            report_field("filtered_re", want.filtered_re, rsp_chan.payload.filtered_re);
            report_field("filtered_im", want.filtered_im, rsp_chan.payload.filtered_im);
         end
      end
   end

   // run limit, well above the slowest legal run including the clearing pass
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // stimulus and end of run
   initial begin
      mfb_pkg::req_type it;
      queued_req_type   q;
      int               item_count;
      int               bank_pool[$];
      int               b;
      int               r;

      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      reset            = 1'b1;
      foreach (line_re[i]) begin
         line_re[i] = '0;
         line_im[i] = '0;
      end
      foreach (line_head[i]) line_head[i] = '0;
      foreach (bank_coef[i]) bank_coef[i] = '0;

      // directed: top bank with full-scale negative coefficients
      for (int t = 0; t < NUM_TAPS; t++) begin
         it = rand_req();
         it.command     = mfb_pkg::CMD_COEF;
         it.in_bank     = 8'hff;
         it.tap_index   = mfb_pkg::TAP_W'(t);
         it.coefficient = 16'sh8000;
         item_backlog.push_back('{it, 1'b0});
      end
      // directed: extreme samples on the top station and station zero
      for (int n = 0; n < 6; n++) begin
         it = rand_req();
         it.command    = mfb_pkg::CMD_FILTER;
         it.in_bank    = 8'hff;
         it.in_station = (n == 4) ? 2'd0 : 2'd3;
         it.sample_re  = (n == 4) ? 16'sh7fff : (n == 5) ? 16'sh0000 : 16'sh8000;
         it.sample_im  = (n == 4) ? 16'sh8000 : (n == 5) ? 16'shffff : 16'sh7fff;
         item_backlog.push_back('{it, 1'b0});
      end
      // directed: rewrite the newest-sample tap, then filter with it
      it = rand_req();
      it.command     = mfb_pkg::CMD_COEF;
      it.in_bank     = 8'hff;
      it.tap_index   = '0;
      it.coefficient = 16'sh7fff;
      item_backlog.push_back('{it, 1'b0});
      it = rand_req();
      it.command    = mfb_pkg::CMD_FILTER;
      it.in_bank    = 8'hff;
      it.in_station = 2'd3;
      it.sample_re  = 16'sh8000;
      it.sample_im  = 16'sh8000;
      item_backlog.push_back('{it, 1'b0});
      bank_pool.push_back(255);
      item_count = item_backlog.size();

      // random: full coefficient loads, single rewrites, and samples on loaded banks
      while (item_count < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (bank_pool.size() < 3 || r < 1) begin
            b = $urandom_range(0, NUM_BANKS - 1);
            for (int t = 0; t < NUM_TAPS; t++) begin
               it = rand_req();
               it.command     = mfb_pkg::CMD_COEF;
               it.in_bank     = mfb_pkg::BANK_W'(b);
               it.tap_index   = mfb_pkg::TAP_W'(t);
               it.coefficient = pick_value();
               item_backlog.push_back('{it, 1'b0});
            end
            bank_pool.push_back(b);
            item_count += NUM_TAPS;
         end else begin
            // favor the most recent banks so delay lines wrap
            if ($urandom_range(0, 9) < 7)
               b = bank_pool[bank_pool.size() - 1 - $urandom_range(0, 2)];
            else
               b = bank_pool[$urandom_range(0, bank_pool.size() - 1)];
            it = rand_req();
            it.in_bank = mfb_pkg::BANK_W'(b);
            if (r < 10) begin
               it.command     = mfb_pkg::CMD_COEF;
               it.coefficient = pick_value();
            end else begin
               it.command   = mfb_pkg::CMD_FILTER;
               it.sample_re = pick_value();
               it.sample_im = pick_value();
            end
            // the first single item after the two opening loads, and a few others,
            // wait for the core to drain
            q.item      = it;
            q.wait_idle = (item_count == 24 + 2 * NUM_TAPS) || ($urandom_range(0, 49) == 0);
            item_backlog.push_back(q);
            item_count++;
         end
      end

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      while (item_backlog.size() != 0 || req_chan.valid) @(posedge clock);
      while (predicted_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### multichannel_fir_filter_bank_core.f
rtl/core/mfb_pkg.sv
rtl/core/mfb_stream_if.sv
rtl/core/mfb_mac.sv
rtl/core/multichannel_fir_filter_bank_core.sv
bench/tb_multichannel_fir_filter_bank_core.sv
